// ===== rtl/core/stnpf_pkg.sv =====
package stnpf_pkg;

	localparam int BIN_W  = 10;
	localparam int MAG_W  = 17;
	localparam int FREQ_W = 28;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// Exclusive upper bound on any reported bin; caps the configured max bin
	localparam logic [BIN_W-1:0] BIN_CAP = 10'd512;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PEAKS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FFT_LOG2    = 3'd5;

	// Cell operations
	localparam logic [2:0] OP_HOLD   = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_TRIM   = 3'd2;
	localparam logic [2:0] OP_SORT   = 3'd3;
	localparam logic [2:0] OP_SHIFT  = 3'd4;

	typedef struct packed {
		logic             valid;
		logic [BIN_W-1:0] bin;
		logic [MAG_W-1:0] mag;
	} entry_t;

	typedef struct packed {
		logic [2:0] op;
		logic       keep;
		logic       pair_right;
		logic       pair_left;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/spectral_top_n_peak_finder_core.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------------
// in       | in_valid / in_ready  | bin_real, bin_imag, last_bin
// out      | out_valid / out_ready| peak_bin, peak_frequency, peak_found, last_peak
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Within a frame one bin is taken per cycle; a bin is judged when its right neighbor
// leaves the magnitude stage and enters the cell chain on the following cycle.
// After the last bin passes the magnitude and judge stages and is inserted, the chain is
// trimmed and odd-even sorted; each result is then multiplied, scaled and held while stalled.
// in_ready stays low from the last bin until the final result is in the
// output register; cfg_ready is always high. arst_n clears all control state and the chain.
module spectral_top_n_peak_finder_core #(
	parameter int MAX_PEAKS   = 8,
	parameter int MAX_FFT_LEN = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [15:0]                  bin_real,
	input  logic signed [15:0]                  bin_imag,
	input  logic                                last_bin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [stnpf_pkg::BIN_W-1:0]         peak_bin,
	output logic [stnpf_pkg::FREQ_W-1:0]        peak_frequency,
	output logic                                peak_found,
	output logic                                last_peak,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [stnpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [stnpf_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import stnpf_pkg::*;

	localparam int CW    = $clog2(MAX_FFT_LEN);
	localparam int CMPW  = (CW > BIN_W) ? CW : BIN_W;
	localparam int NW    = $clog2(MAX_PEAKS + 1);
	localparam int NWX   = (NW > 4) ? NW : 4;
	localparam int PRODW = 30;
	localparam int WIDEW = PRODW + 8;

	localparam logic [2:0] ST_COLLECT = 3'd0;
	localparam logic [2:0] ST_TRIM    = 3'd1;
	localparam logic [2:0] ST_SORT    = 3'd2;
	localparam logic [2:0] ST_LOAD    = 3'd3;
	localparam logic [2:0] ST_EMIT    = 3'd4;

	// Configuration
	logic [BIN_W-1:0] min_bin_q;
	logic [BIN_W-1:0] max_bin_q;
	logic [15:0]      threshold_q;
	logic [3:0]       peaks_wanted_q;
	logic [19:0]      sample_rate_q;
	logic [3:0]       fft_log2_q;

	logic [2:0]       state_q;
	logic             end_q;
	logic [NW-1:0]    sort_cnt_q;
	logic [NW-1:0]    out_cnt_q;
	logic [NW-1:0]    wanted;
	logic [NWX-1:0]   pw_ext;

	// Bin pipeline
	logic             valid_s1;
	logic             last_s1;
	logic [MAG_W-1:0] mag_s1;
	logic             valid_s2;
	logic             last_s2;
	entry_t           cand_s2;
	logic [CW-1:0]    cnt_q;
	logic [MAG_W-1:0] prev_q;
	logic [MAG_W-1:0] prev_prev_q;

	logic             in_acc;
	logic [MAG_W-1:0] abs_re;
	logic [MAG_W-1:0] abs_im;
	logic [CW-1:0]    cur_idx;
	logic [BIN_W-1:0] hi_bin;
	logic             is_peak;

	// Chain
	logic [2:0]       chain_op;
	entry_t           ents [MAX_PEAKS];
	logic [MAX_PEAKS-1:0] beats_v;
	logic [MAX_PEAKS-1:0] vld;

	// Output path
	logic [PRODW-1:0] prod_q;
	logic [BIN_W-1:0] hd_bin_q;
	logic             hd_found_q;
	logic             hd_last_q;
	logic             out_valid_q;
	logic [BIN_W-1:0] peak_bin_q;
	logic [FREQ_W-1:0] freq_q;
	logic             found_q;
	logic             last_q;
	logic             load_out;
	logic [WIDEW-1:0] wide;
	logic [FREQ_W-1:0] freq_sat;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_COLLECT) && !end_q;
	assign in_acc    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bin_q      <= '0;
			max_bin_q      <= 10'd512;
			threshold_q    <= '0;
			peaks_wanted_q <= 4'd4;
			sample_rate_q  <= 20'd16000;
			fft_log2_q     <= 4'd9;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_BIN:     min_bin_q      <= cfg_data[BIN_W-1:0];
				CFG_MAX_BIN:     max_bin_q      <= cfg_data[BIN_W-1:0];
				CFG_THRESHOLD:   threshold_q    <= cfg_data[15:0];
				CFG_PEAKS:       peaks_wanted_q <= cfg_data[3:0];
				CFG_SAMPLE_RATE: sample_rate_q  <= cfg_data[19:0];
				CFG_FFT_LOG2:    fft_log2_q     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Clamp the peak count to 1..MAX_PEAKS
	assign pw_ext = NWX'(peaks_wanted_q);
	always_comb begin
		if (peaks_wanted_q == 4'd0) begin
			wanted = NW'(1);
		end else if (pw_ext > NWX'(MAX_PEAKS)) begin
			wanted = NW'(MAX_PEAKS);
		end else begin
			wanted = NW'(pw_ext);
		end
	end

	// Stage 1: magnitude
	assign abs_re = bin_real[15] ? (MAG_W'(0) - {bin_real[15], bin_real})
	                             : {1'b0, bin_real};
	assign abs_im = bin_imag[15] ? (MAG_W'(0) - {bin_imag[15], bin_imag})
	                             : {1'b0, bin_imag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mag_s1  <= abs_re + abs_im;
			last_s1 <= last_bin;
		end
	end

	// Stage 2: judge the previous bin now that its right neighbor is known
	assign cur_idx = cnt_q - CW'(1);
	assign hi_bin  = (max_bin_q > BIN_CAP) ? BIN_CAP : max_bin_q;
	assign is_peak = (cnt_q != '0)
		&& (CMPW'(cur_idx) > CMPW'(min_bin_q))
		&& (CMPW'(cur_idx) < CMPW'(hi_bin))
		&& (prev_q > MAG_W'(threshold_q))
		&& (prev_q > prev_prev_q)
		&& (prev_q > mag_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			prev_q      <= '0;
			prev_prev_q <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				cnt_q       <= '0;
				prev_q      <= '0;
				prev_prev_q <= '0;
			end else begin
				prev_prev_q <= prev_q;
				prev_q      <= mag_s1;
				if (cnt_q != CW'(MAX_FFT_LEN - 1)) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			cand_s2.valid <= is_peak;
			cand_s2.bin   <= BIN_W'(cur_idx);
			cand_s2.mag   <= prev_q;
			last_s2       <= last_s1;
		end
	end

	// Frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_COLLECT;
			end_q      <= 1'b0;
			sort_cnt_q <= '0;
			out_cnt_q  <= '0;
		end else begin
			if (in_acc && last_bin) begin
				end_q <= 1'b1;
			end
			case (state_q)
				ST_COLLECT: begin
					if (valid_s2 && last_s2) begin
						state_q <= ST_TRIM;
					end
				end
				ST_TRIM: begin
					sort_cnt_q <= '0;
					out_cnt_q  <= '0;
					state_q    <= ST_SORT;
				end
				ST_SORT: begin
					sort_cnt_q <= sort_cnt_q + NW'(1);
					if (sort_cnt_q == NW'(MAX_PEAKS - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load_out) begin
						out_cnt_q <= out_cnt_q + NW'(1);
						if (hd_last_q) begin
							state_q <= ST_COLLECT;
							end_q   <= 1'b0;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	always_comb begin
		case (state_q)
			ST_COLLECT: chain_op = (valid_s2 && cand_s2.valid) ? OP_INSERT : OP_HOLD;
			ST_TRIM:    chain_op = OP_TRIM;
			ST_SORT:    chain_op = OP_SORT;
			ST_LOAD:    chain_op = OP_SHIFT;
			default:    chain_op = OP_HOLD;
		endcase
	end

	// Cell chain: descending magnitude while collecting, ascending bin after sort
	for (genvar k = 0; k < MAX_PEAKS; k++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     left_ent;
		entry_t     right_ent;
		logic       left_beats;

		assign ctrl.op         = chain_op;
		assign ctrl.keep       = NW'(k) < wanted;
		assign ctrl.pair_right = (1'(k % 2) == sort_cnt_q[0]) && (k < MAX_PEAKS - 1);
		assign ctrl.pair_left  = (1'(k % 2) != sort_cnt_q[0]) && (k > 0);

		if (k == 0) begin : g_head
			assign left_ent   = '0;
			assign left_beats = 1'b0;
		end else begin : g_mid
			assign left_ent   = ents[k-1];
			assign left_beats = beats_v[k-1];
		end

		if (k == MAX_PEAKS - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_inner
			assign right_ent = ents[k+1];
		end

		stnpf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_ent    (cand_s2),
			.left_ent   (left_ent),
			.right_ent  (right_ent),
			.left_beats (left_beats),
			.ent        (ents[k]),
			.beats      (beats_v[k])
		);

		assign vld[k] = ents[k].valid;
	end

	// Head capture and multiply
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			hd_bin_q   <= ents[0].valid ? ents[0].bin : '0;
			hd_found_q <= ents[0].valid;
			hd_last_q  <= (out_cnt_q == wanted - NW'(1));
			prod_q     <= PRODW'(ents[0].valid ? ents[0].bin : '0) * PRODW'(sample_rate_q);
		end
	end

	// Scale to Q20.8 and saturate
	assign wide     = {prod_q, 8'd0} >> fft_log2_q;
	assign freq_sat = (|wide[WIDEW-1:FREQ_W]) ? {FREQ_W{1'b1}} : wide[FREQ_W-1:0];
	assign load_out = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			peak_bin_q <= hd_bin_q;
			freq_q     <= freq_sat;
			found_q    <= hd_found_q;
			last_q     <= hd_last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign peak_bin       = peak_bin_q;
	assign peak_frequency = freq_q;
	assign peak_found     = found_q;
	assign last_peak      = last_q;

	// Filled slots always form a prefix of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, vld} + (MAX_PEAKS + 1)'(1)))
		else $error("peak chain has a gap");

	a_insert_collect: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> state_q == ST_COLLECT)
		else $error("insertion outside collection");

	a_last_count: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && hd_last_q) |-> out_cnt_q == wanted - NW'(1))
		else $error("final result at wrong slot count");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable({peak_bin, peak_frequency, peak_found, last_peak})))
		else $error("result changed while stalled");

endmodule

// ===== rtl/core/stnpf_cell.sv =====
module stnpf_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  stnpf_pkg::cell_ctrl_t  ctrl,
	input  stnpf_pkg::entry_t      new_ent,
	input  stnpf_pkg::entry_t      left_ent,
	input  stnpf_pkg::entry_t      right_ent,
	input  logic                   left_beats,
	output stnpf_pkg::entry_t      ent,
	output logic                   beats
);
	import stnpf_pkg::*;

	logic             valid_q;
	logic [BIN_W-1:0] bin_q;
	logic [MAG_W-1:0] mag_q;
	entry_t           nxt;
	logic [BIN_W:0]   key_self;
	logic [BIN_W:0]   key_left;
	logic [BIN_W:0]   key_right;

	assign ent = '{valid: valid_q, bin: bin_q, mag: mag_q};

	// This slot loses to the new entry; ties keep the older entry ahead
	assign beats = !valid_q || (mag_q < new_ent.mag);

	// Empty slots sort behind every real one
	assign key_self  = {~valid_q, bin_q};
	assign key_left  = {~left_ent.valid, left_ent.bin};
	assign key_right = {~right_ent.valid, right_ent.bin};

	always_comb begin
		nxt = ent;
		case (ctrl.op)
			OP_INSERT: begin
				if (!ctrl.keep) begin
					nxt.valid = 1'b0;
				end else if (beats) begin
					nxt = left_beats ? left_ent : new_ent;
				end
			end
			OP_TRIM: begin
				if (!ctrl.keep) begin
					nxt.valid = 1'b0;
				end
			end
			OP_SORT: begin
				if (ctrl.pair_right && (key_self > key_right)) begin
					nxt = right_ent;
				end else if (ctrl.pair_left && (key_left > key_self)) begin
					nxt = left_ent;
				end
			end
			OP_SHIFT: nxt = right_ent;
			default: nxt = ent;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		bin_q <= nxt.bin;
		mag_q <= nxt.mag;
	end

endmodule
